[design/tse_pkg.sv]
// tse_pkg: constants, types and the coefficient table of the Taylor sine evaluator.
// Used by taylor_sine_evaluator; no dependencies.
package tse_pkg;

    localparam int DATA_W        = 32;
    localparam int ACC_W         = 64;
    localparam int PROD_W        = 2 * ACC_W;
    localparam int HALF_W        = ACC_W / 2;
    localparam int MAX_TERMS     = 32;
    localparam int NUM_TERMS_DEF = 20;
    localparam int RED_STEPS     = 5;

    // 2*pi in Q56, rounded to nearest
    localparam logic [ACC_W-1:0] TWO_PI_Q56 = 64'h06487ED5110B4612;

    // product shifts: x*x Q56*Q56->Q56, acc*v Q56*Q60->Q56, acc*u Q56*Q58->Q30
    localparam int SH_SQ   = 56;
    localparam int SH_HORN = 60;
    localparam int SH_FIN  = 84;

    localparam logic signed [ACC_W-1:0] ONE_Q30     = 64'sd1073741824;
    localparam logic signed [ACC_W-1:0] NEG_ONE_Q30 = -64'sd1073741824;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED,
        ST_SIGN,
        ST_MLOAD,
        ST_MMUL,
        ST_MRND,
        ST_HADD
    } t_state;

    typedef enum logic [1:0] {
        PH_SQ,
        PH_HORN,
        PH_FIN
    } t_phase;

    typedef logic [MAX_TERMS-1:0][ACC_W-1:0] t_coef_tab;

    // |d_i| = 4^(2i+1)/(2i+1)! in Q56, each floored from the previous one
    // quotient by shift and subtract
    function automatic t_coef_tab sine_coef_tab();
        t_coef_tab        tab;
        logic [ACC_W+3:0] num;
        logic [ACC_W+3:0] dv;
        logic [ACC_W+3:0] rem;
        logic [ACC_W+3:0] quo;
        tab    = '0;
        tab[0] = 64'd1 << 58;
        for (int i = 1; i < MAX_TERMS; i++) begin
            dv  = (ACC_W + 4)'((2 * i) * (2 * i + 1));
            num = {tab[i-1], 4'b0000};
            rem = '0;
            quo = '0;
            for (int b = ACC_W + 3; b >= 0; b--) begin
                rem = {rem[ACC_W+2:0], num[b]};
                if (rem >= dv) begin
                    rem    = rem - dv;
                    quo[b] = 1'b1;
                end
            end
            tab[i] = quo[ACC_W-1:0];
        end
        return tab;
    endfunction

endpackage

[design/taylor_sine_evaluator.sv]
// taylor_sine_evaluator: sine of a Q8.24 angle by range reduction and a Horner series.
// Depends on tse_pkg (constants, state types, coefficient table).
//
//  channel   signals                      transfer
//  -------   --------------------------   ---------------------------------------
//  input     start, busy, i_angle_rad     edge with start high and busy low
//  result    o_valid, o_sine_value        edge that ends the cycle o_valid is high
//
//  One shared 32x32 multiplier builds each 64x64 product from four partial products.
//  o_valid rises after the transfer edge once these states have run in order:
//  5 reduction steps, 1 sign step, MLOAD/MMUL/MRND per product, 1 add per Horner term.
//  busy is low again in the o_valid cycle, so the next start may be taken there.
//  i_rst_n is synchronous; it drops any item in flight and clears o_valid.
//  The receiver cannot stall; each result is shown for exactly one cycle.
module taylor_sine_evaluator
    import tse_pkg::*;
#(
    parameter int NUM_TERMS = NUM_TERMS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] i_angle_rad,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_sine_value
);

    localparam int        IDX_W     = $clog2(NUM_TERMS);
    localparam t_coef_tab COEF_TAB  = sine_coef_tab();
    localparam logic signed [ACC_W-1:0] COEF_LAST = $signed(COEF_TAB[NUM_TERMS-1]);
    localparam logic signed [ACC_W-1:0] ACC_INIT  =
        (((NUM_TERMS - 1) % 2) != 0) ? -COEF_LAST : COEF_LAST;
    localparam logic [IDX_W-1:0] FIRST_IDX = IDX_W'(NUM_TERMS - 2);

    localparam logic [PROD_W-1:0] RND_SQ   = PROD_W'(1) << (SH_SQ - 1);
    localparam logic [PROD_W-1:0] RND_HORN = PROD_W'(1) << (SH_HORN - 1);
    localparam logic [PROD_W-1:0] RND_FIN  = PROD_W'(1) << (SH_FIN - 1);
    localparam logic [2:0]        MUL_LAST = 3'd4;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    logic                     r_neg,   n_neg;
    logic [ACC_W-1:0]         r_x,     n_x;
    logic [2:0]               r_cnt,   n_cnt;
    logic signed [ACC_W-1:0]  r_r,     n_r;
    logic signed [ACC_W-1:0]  r_v,     n_v;
    logic signed [ACC_W-1:0]  r_acc,   n_acc;
    logic signed [ACC_W-1:0]  r_mres,  n_mres;
    logic [ACC_W-1:0]         r_ma,    n_ma;
    logic [ACC_W-1:0]         r_mb,    n_mb;
    logic                     r_pneg,  n_pneg;
    logic [2:0]               r_k,     n_k;
    logic [ACC_W-1:0]         r_pp,    n_pp;
    logic [PROD_W-1:0]        r_prod,  n_prod;
    logic [IDX_W-1:0]         r_i,     n_i;
    logic signed [DATA_W-1:0] r_sine,  n_sine;
    logic                     r_valid, n_valid;

    logic [DATA_W:0]          in_mag;
    logic [ACC_W-1:0]         red_trial;
    logic signed [ACC_W-1:0]  op_a, op_b;
    logic [HALF_W-1:0]        mul_a, mul_b;
    logic [PROD_W-1:0]        pp_ext;
    logic [PROD_W-1:0]        rnd_sum, rnd_shift;
    logic [ACC_W-1:0]         rnd_mag;
    logic signed [ACC_W-1:0]  rnd_res;
    logic signed [ACC_W-1:0]  coef_s;
    logic signed [ACC_W:0]    add_sum;
    logic signed [ACC_W-1:0]  add_res;

    assign busy         = (r_state != ST_IDLE);
    assign o_valid      = r_valid;
    assign o_sine_value = r_sine;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_SQ;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg  <= n_neg;
        r_x    <= n_x;
        r_cnt  <= n_cnt;
        r_r    <= n_r;
        r_v    <= n_v;
        r_acc  <= n_acc;
        r_mres <= n_mres;
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_pneg <= n_pneg;
        r_k    <= n_k;
        r_pp   <= n_pp;
        r_prod <= n_prod;
        r_i    <= n_i;
        r_sine <= n_sine;
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_neg   = r_neg;
        n_x     = r_x;
        n_cnt   = r_cnt;
        n_r     = r_r;
        n_v     = r_v;
        n_acc   = r_acc;
        n_mres  = r_mres;
        n_ma    = r_ma;
        n_mb    = r_mb;
        n_pneg  = r_pneg;
        n_k     = r_k;
        n_pp    = r_pp;
        n_prod  = r_prod;
        n_i     = r_i;
        n_sine  = r_sine;
        n_valid = 1'b0;

        // angle magnitude; the most negative code gives 2^31
        in_mag = i_angle_rad[DATA_W-1] ? ((DATA_W + 1)'(0) - {i_angle_rad[DATA_W-1], i_angle_rad})
                                       : {1'b0, i_angle_rad};

        red_trial = TWO_PI_Q56 << r_cnt;

        case (r_phase)
            PH_SQ: begin
                op_a = r_r;
                op_b = r_r;
            end
            PH_HORN: begin
                op_a = r_acc;
                op_b = r_v;
            end
            PH_FIN: begin
                op_a = r_acc;
                op_b = r_r;
            end
            default: begin
                op_a = r_acc;
                op_b = r_r;
            end
        endcase

        // partial products: lo*lo, lo*hi, hi*lo, hi*hi
        mul_a = (r_k[1] && !r_k[2]) ? r_ma[ACC_W-1:HALF_W] : r_ma[HALF_W-1:0];
        mul_b = (r_k[0] && !r_k[2]) ? r_mb[ACC_W-1:HALF_W] : r_mb[HALF_W-1:0];

        case (r_k)
            3'd1:    pp_ext = {{ACC_W{1'b0}}, r_pp};
            3'd2:    pp_ext = {{ACC_W{1'b0}}, r_pp} << HALF_W;
            3'd3:    pp_ext = {{ACC_W{1'b0}}, r_pp} << HALF_W;
            3'd4:    pp_ext = {{ACC_W{1'b0}}, r_pp} << ACC_W;
            default: pp_ext = '0;
        endcase

        case (r_phase)
            PH_SQ: begin
                rnd_sum   = r_prod + RND_SQ;
                rnd_shift = rnd_sum >> SH_SQ;
            end
            PH_HORN: begin
                rnd_sum   = r_prod + RND_HORN;
                rnd_shift = rnd_sum >> SH_HORN;
            end
            PH_FIN: begin
                rnd_sum   = r_prod + RND_FIN;
                rnd_shift = rnd_sum >> SH_FIN;
            end
            default: begin
                rnd_sum   = r_prod + RND_FIN;
                rnd_shift = rnd_sum >> SH_FIN;
            end
        endcase
        rnd_mag = (|rnd_shift[PROD_W-1:ACC_W-1]) ? {1'b0, {(ACC_W - 1){1'b1}}}
                                                 : rnd_shift[ACC_W-1:0];
        rnd_res = r_pneg ? -$signed(rnd_mag) : $signed(rnd_mag);

        coef_s  = r_i[0] ? -$signed(COEF_TAB[r_i]) : $signed(COEF_TAB[r_i]);
        add_sum = {coef_s[ACC_W-1], coef_s} + {r_mres[ACC_W-1], r_mres};
        if (add_sum[ACC_W] != add_sum[ACC_W-1]) begin
            add_res = add_sum[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}}
                                     : {1'b0, {(ACC_W - 1){1'b1}}};
        end else begin
            add_res = add_sum[ACC_W-1:0];
        end

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_neg   = i_angle_rad[DATA_W-1];
                    n_x     = {in_mag[DATA_W-1:0], {DATA_W{1'b0}}} | ({ACC_W{in_mag[DATA_W]}}
                              & {1'b1, {(ACC_W - 1){1'b0}}});
                    n_cnt   = 3'(RED_STEPS - 1);
                    n_state = ST_RED;
                end
            end
            ST_RED: begin
                if (r_x >= red_trial) begin
                    n_x = r_x - red_trial;
                end
                n_cnt = r_cnt - 3'd1;
                if (r_cnt == 3'd0) begin
                    n_state = ST_SIGN;
                end
            end
            ST_SIGN: begin
                n_r     = r_neg ? -$signed(r_x) : $signed(r_x);
                n_phase = PH_SQ;
                n_state = ST_MLOAD;
            end
            ST_MLOAD: begin
                n_ma    = op_a[ACC_W-1] ? (ACC_W'(0) - op_a) : op_a;
                n_mb    = op_b[ACC_W-1] ? (ACC_W'(0) - op_b) : op_b;
                n_pneg  = op_a[ACC_W-1] ^ op_b[ACC_W-1];
                n_prod  = '0;
                n_k     = 3'd0;
                n_state = ST_MMUL;
            end
            ST_MMUL: begin
                n_pp   = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};
                n_prod = r_prod + pp_ext;
                n_k    = r_k + 3'd1;
                if (r_k == MUL_LAST) begin
                    n_state = ST_MRND;
                end
            end
            ST_MRND: begin
                n_mres = rnd_res;
                case (r_phase)
                    PH_SQ: begin
                        n_v     = rnd_res;
                        n_acc   = ACC_INIT;
                        n_i     = FIRST_IDX;
                        n_phase = PH_HORN;
                        n_state = ST_MLOAD;
                    end
                    PH_HORN: begin
                        n_state = ST_HADD;
                    end
                    default: begin
                        if (rnd_res > ONE_Q30) begin
                            n_sine = DATA_W'(ONE_Q30);
                        end else if (rnd_res < NEG_ONE_Q30) begin
                            n_sine = DATA_W'(NEG_ONE_Q30);
                        end else begin
                            n_sine = rnd_res[DATA_W-1:0];
                        end
                        n_valid = 1'b1;
                        n_state = ST_IDLE;
                    end
                endcase
            end
            ST_HADD: begin
                n_acc   = add_res;
                n_i     = r_i - IDX_W'(1);
                n_state = ST_MLOAD;
                if (r_i == '0) begin
                    n_phase = PH_FIN;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    a_red_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SIGN) |-> (r_x < TWO_PI_Q56))
        else $error("reduced angle not below 2*pi");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transfer not followed by busy");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sine_value <= 32'sd1073741824 && o_sine_value >= -32'sd1073741824))
        else $error("sine outside plus or minus one");

endmodule
